>>> rtl/bmh_pkg.sv
`default_nettype none
package bmh_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned REF_BITS = 16;

  localparam int unsigned ADDR_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);
  // child index 2*pos+2 needs two bits beyond the address
  localparam int unsigned POS_W   = ADDR_W + 2;
  localparam int unsigned ENTRY_W = KEY_BITS + REF_BITS;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_ROOT,
    S_DN_MV,
    S_DN_L,
    S_DN_R,
    S_DN_SEL,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [REF_BITS-1:0] rf;
  } entry_t;

  typedef struct packed {
    entry_t           ent;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/bmh_ram.sv
`default_nettype none
module bmh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/bmh_ctrl.sv
`default_nettype none
module bmh_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [1:0]                cmd_i,
  input  wire logic [bmh_pkg::REF_BITS-1:0] entry_ref_i,
  input  wire logic [bmh_pkg::KEY_BITS-1:0] entry_key_i,
  output logic                           mem_we_o,
  output logic [bmh_pkg::ADDR_W-1:0]     mem_waddr_o,
  output bmh_pkg::entry_t                mem_wdata_o,
  output logic [bmh_pkg::ADDR_W-1:0]     mem_raddr_o,
  input  wire bmh_pkg::entry_t           mem_rdata_i,
  output logic                           res_valid_o,
  input  wire logic                      res_ready_i,
  output bmh_pkg::result_t               res_o
);
  import bmh_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] lidx_q, lidx_d;
  logic              has_r_q, has_r_d;
  entry_t            mov_q, mov_d;
  entry_t            left_q, left_d;
  entry_t            res_ent_q, res_ent_d;
  logic [1:0]        status_q, status_d;

  logic [POS_W-1:0]  lft, rgt, cnt_ext;
  logic [ADDR_W-1:0] par_idx;
  logic [CNT_W-1:0]  cnt_m1;
  entry_t            pick;
  logic [ADDR_W-1:0] pick_idx;

  assign lft      = {1'b0, pos_q, 1'b1};
  assign rgt      = lft + POS_W'(1);
  assign cnt_ext  = POS_W'(count_q);
  assign par_idx  = (pos_q - ADDR_W'(1)) >> 1;
  assign cnt_m1   = count_q - CNT_W'(1);

  // right child wins only when strictly smaller
  always_comb begin
    if (has_r_q && (mem_rdata_i.key < left_q.key)) begin
      pick     = mem_rdata_i;
      pick_idx = lidx_q + ADDR_W'(1);
    end else begin
      pick     = left_q;
      pick_idx = lidx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    lidx_q    <= lidx_d;
    has_r_q   <= has_r_d;
    mov_q     <= mov_d;
    left_q    <= left_d;
    res_ent_q <= res_ent_d;
    status_q  <= status_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    lidx_d      = lidx_q;
    has_r_d     = has_r_q;
    mov_d       = mov_q;
    left_d      = left_q;
    res_ent_d   = res_ent_q;
    status_d    = status_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = pos_q;
    mem_wdata_o = mov_q;
    mem_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_ent_d = '0;
          status_d  = ST_OK;
          state_d   = S_FIN;
          case (cmd_i)
            CMD_INSERT: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                status_d = ST_FULL;
              end else begin
                mov_d   = '{key: entry_key_i, rf: entry_ref_i};
                pos_d   = count_q[ADDR_W-1:0];
                count_d = count_q + CNT_W'(1);
                state_d = S_UP_RD;
              end
            end
            CMD_DELETE: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                state_d = S_DN_ROOT; // root read issued this cycle
              end
            end
            CMD_CLEAR: count_d = '0;
            default: ;
          endcase
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
          state_d  = S_FIN;
        end else begin
          mem_raddr_o = par_idx;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we_o = 1'b1;
        if (mem_rdata_i.key > mov_q.key) begin
          // parent moves down into the hole
          mem_wdata_o = mem_rdata_i;
          pos_d       = par_idx;
          state_d     = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DN_ROOT: begin
        res_ent_d   = mem_rdata_i;
        mem_raddr_o = cnt_m1[ADDR_W-1:0];
        count_d     = cnt_m1;
        pos_d       = '0;
        state_d     = S_DN_MV;
      end
      S_DN_MV: begin
        mov_d   = mem_rdata_i;
        state_d = S_DN_L;
      end
      S_DN_L: begin
        if (lft >= cnt_ext) begin
          mem_we_o = 1'b1;
          state_d  = S_FIN;
        end else begin
          mem_raddr_o = lft[ADDR_W-1:0];
          lidx_d      = lft[ADDR_W-1:0];
          state_d     = S_DN_R;
        end
      end
      S_DN_R: begin
        left_d  = mem_rdata_i;
        has_r_d = rgt < cnt_ext;
        mem_raddr_o = rgt[ADDR_W-1:0];
        state_d = S_DN_SEL;
      end
      S_DN_SEL: begin
        mem_we_o = 1'b1;
        if (mov_q.key > pick.key) begin
          mem_wdata_o = pick;
          pos_d       = pick_idx;
          state_d     = S_DN_L;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o = '{ent: res_ent_q, status: status_q, count: count_q};

endmodule
`default_nettype wire

>>> rtl/bmh_out_reg.sv
`default_nettype none
module bmh_out_reg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       res_valid_i,
  output logic                            res_ready_o,
  input  wire bmh_pkg::result_t           res_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [bmh_pkg::REF_BITS-1:0]    out_ref_o,
  output logic [bmh_pkg::KEY_BITS-1:0]    out_key_o,
  output logic [1:0]                      status_o,
  output logic [bmh_pkg::CNT_W-1:0]       entry_count_o,
  output logic                            has_more_o
);
  import bmh_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q, data_d;

  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (out_ready_i) begin
      valid_d = 1'b0;
    end
    if (res_valid_i && res_ready_o) begin
      valid_d = 1'b1;
      data_d  = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o   = valid_q;
  assign out_ref_o     = data_q.ent.rf;
  assign out_key_o     = data_q.ent.key;
  assign status_o      = data_q.status;
  assign entry_count_o = data_q.count;
  assign has_more_o    = data_q.count != '0;

endmodule
`default_nettype wire

>>> rtl/binary_min_heap_priority_queue.sv
// sequence: clear, refused or unknown commands go straight to the result state; an insert into
// an empty heap writes the root at once, else climbs with a parent read and compare per level;
// a delete reads the root and the last entry, then per level reads both children and selects
// throughput: the next item is taken only after the result has entered the output register;
// each level costs a read (two going down), a compare and a write on the single-read-port memory
// reset: heap empty, no item pending; the entry memory is not cleared
`default_nettype none
module binary_min_heap_priority_queue (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   cmd_i,
  input  wire logic [bmh_pkg::REF_BITS-1:0] entry_ref_i,
  input  wire logic [bmh_pkg::KEY_BITS-1:0] entry_key_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [bmh_pkg::REF_BITS-1:0]      out_ref_o,
  output logic [bmh_pkg::KEY_BITS-1:0]      out_key_o,
  output logic [1:0]                        status_o,
  output logic [bmh_pkg::CNT_W-1:0]         entry_count_o,
  output logic                              has_more_o
);
  import bmh_pkg::*;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  entry_t            mem_wdata, mem_rdata;
  logic              res_valid, res_ready;
  result_t           res;

  bmh_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  bmh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .entry_ref_i(entry_ref_i),
    .entry_key_i(entry_key_i),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  bmh_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (res_valid),
    .res_ready_o  (res_ready),
    .res_i        (res),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_ref_o    (out_ref_o),
    .out_key_o    (out_key_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .has_more_o   (has_more_o)
  );

endmodule
`default_nettype wire

>>> rtl/bmh_checker.sv
`default_nettype none
module bmh_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [bmh_pkg::REF_BITS-1:0] out_ref_o,
  input wire logic [bmh_pkg::KEY_BITS-1:0] out_key_o,
  input wire logic [1:0]                   status_o,
  input wire logic [bmh_pkg::CNT_W-1:0]    entry_count_o,
  input wire logic                         has_more_o
);
  import bmh_pkg::*;

  a_more_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (has_more_o == (entry_count_o != '0)))
    else $error("has_more disagrees with entry count");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (entry_count_o == CNT_W'(CAPACITY)))
    else $error("insert refused below capacity");

  a_empty_has_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY)
      |-> (entry_count_o == '0 && out_key_o == '0 && out_ref_o == '0))
    else $error("empty delete reported data or entries");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_key_o)
      && $stable(entry_count_o)))
    else $error("result dropped or changed while stalled");

endmodule

bind binary_min_heap_priority_queue bmh_checker u_bmh_checker (.*);
`default_nettype wire

>>> tb/heap_order_checker.sv
`timescale 1ns / 1ps
module heap_order_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [1:0]                   cmd_i,
  input  logic [bmh_pkg::REF_BITS-1:0] entry_ref_i,
  input  logic [bmh_pkg::KEY_BITS-1:0] entry_key_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [bmh_pkg::REF_BITS-1:0] out_ref_i,
  input  logic [bmh_pkg::KEY_BITS-1:0] out_key_i,
  input  logic [1:0]                   status_i,
  input  logic [bmh_pkg::CNT_W-1:0]    entry_count_i,
  input  logic                         has_more_i,
  output int unsigned                  mismatch_o,
  output int unsigned                  due_o,
  output int unsigned                  checked_o,
  output int unsigned                  full_refusals_o,
  output int unsigned                  empty_deletes_o,
  output int unsigned                  peak_fill_o
);
  import bmh_pkg::*;

  typedef struct {
    logic [REF_BITS-1:0] rf;
    logic [KEY_BITS-1:0] key;
    status_e             status;
    logic [CNT_W-1:0]    count;
    logic                more;
  } heap_reply_t;

  logic [KEY_BITS-1:0] shadow_key [CAPACITY];
  logic [REF_BITS-1:0] shadow_ref [CAPACITY];
  int unsigned         shadow_fill;
  heap_reply_t         replies_due [$];

  function automatic void exchange_slots(input int unsigned a, input int unsigned b);
    logic [KEY_BITS-1:0] k;
    logic [REF_BITS-1:0] r;
    k = shadow_key[a];
    r = shadow_ref[a];
    shadow_key[a] = shadow_key[b];
    shadow_ref[a] = shadow_ref[b];
    shadow_key[b] = k;
    shadow_ref[b] = r;
  endfunction

  function automatic heap_reply_t heap_apply(input logic [1:0] op,
                                             input logic [REF_BITS-1:0] rf,
                                             input logic [KEY_BITS-1:0] key);
    heap_reply_t rep;
    int unsigned pos;
    int unsigned up;
    int unsigned kid_l;
    int unsigned kid_r;
    int unsigned child;
    bit          settled;
    rep.rf = '0;
    rep.key = '0;
    rep.status = ST_OK;
    case (op)
      CMD_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          rep.status = ST_FULL;
          full_refusals_o++;
        end else begin
          shadow_key[shadow_fill] = key;
          shadow_ref[shadow_fill] = rf;
          pos = shadow_fill;
          shadow_fill++;
          settled = 1'b0;
          // climb while the parent is strictly greater
          while (pos > 0 && !settled) begin
            up = (pos - 1) / 2;
            if (shadow_key[up] > shadow_key[pos]) begin
              exchange_slots(up, pos);
              pos = up;
            end else begin
              settled = 1'b1;
            end
          end
        end
      end
      CMD_DELETE: begin
        if (shadow_fill == 0) begin
          rep.status = ST_EMPTY;
          empty_deletes_o++;
        end else begin
          rep.key = shadow_key[0];
          rep.rf = shadow_ref[0];
          shadow_fill--;
          shadow_key[0] = shadow_key[shadow_fill];
          shadow_ref[0] = shadow_ref[shadow_fill];
          pos = 0;
          settled = 1'b0;
          while (!settled) begin
            kid_l = 2 * pos + 1;
            kid_r = kid_l + 1;
            if (kid_l >= shadow_fill) begin
              settled = 1'b1;
            end else begin
              // right child wins only on a strictly smaller key
              child = kid_l;
              if (kid_r < shadow_fill && shadow_key[kid_r] < shadow_key[kid_l]) begin
                child = kid_r;
              end
              if (shadow_key[pos] > shadow_key[child]) begin
                exchange_slots(pos, child);
                pos = child;
              end else begin
                settled = 1'b1;
              end
            end
          end
        end
      end
      CMD_CLEAR: shadow_fill = 0;
      default: ;
    endcase
    rep.count = CNT_W'(shadow_fill);
    rep.more = (shadow_fill != 0);
    if (shadow_fill > peak_fill_o) peak_fill_o = shadow_fill;
    return rep;
  endfunction

  function automatic void check_field(input string field, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      mismatch_o++;
    end
  endfunction

  always @(posedge clk_i) begin
    heap_reply_t want;
    if (!rst_ni) begin
      shadow_fill = 0;
      replies_due.delete();
      mismatch_o = 0;
      checked_o = 0;
      full_refusals_o = 0;
      empty_deletes_o = 0;
      peak_fill_o = 0;
    end else begin
      // a result always trails its item, so it is popped before the new item is queued
      if (out_valid_i && out_ready_i) begin
        if (replies_due.size() == 0) begin
          $display({"%0t: result with nothing outstanding, expected none, ",
                    "actual ref 0x%0h key 0x%0h status %0d count %0d"},
                   $time, out_ref_i, out_key_i, status_i, entry_count_i);
          mismatch_o++;
        end else begin
          want = replies_due.pop_front();
          check_field("out_ref", want.rf, out_ref_i);
          check_field("out_key", want.key, out_key_i);
          check_field("status", want.status, status_i);
          check_field("entry_count", want.count, entry_count_i);
          check_field("has_more", want.more, has_more_i);
          checked_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        replies_due.insert(replies_due.size(), heap_apply(cmd_i, entry_ref_i, entry_key_i));
      end
    end
    due_o = replies_due.size();
  end

endmodule

>>> tb/tb_binary_min_heap_priority_queue.sv
`timescale 1ns / 1ps
module tb_binary_min_heap_priority_queue;
  import bmh_pkg::*;

  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned SQUEEZE_CYCLES = 400;
  localparam int unsigned MIXED_ITEMS    = 550;
  localparam int unsigned CLOSING_ITEMS  = 150;
  localparam int unsigned DRAIN_CYCLES   = 40;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [1:0]          cmd = CMD_INSERT;
  logic [REF_BITS-1:0] entry_ref = '0;
  logic [KEY_BITS-1:0] entry_key = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [REF_BITS-1:0] out_ref;
  logic [KEY_BITS-1:0] out_key;
  logic [1:0]          status;
  logic [CNT_W-1:0]    entry_count;
  logic                has_more;

  int unsigned mismatches;
  int unsigned due;
  int unsigned checked;
  int unsigned full_refusals;
  int unsigned empty_deletes;
  int unsigned peak_fill;

  int unsigned cycle_count = 0;
  int unsigned sent_items = 0;
  bit          tx_idle = 1'b0;
  bit          rx_idle = 1'b0;
  bit          squeeze_req = 1'b0;

  binary_min_heap_priority_queue dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .entry_ref_i   (entry_ref),
    .entry_key_i   (entry_key),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .out_ref_o     (out_ref),
    .out_key_o     (out_key),
    .status_o      (status),
    .entry_count_o (entry_count),
    .has_more_o    (has_more)
  );

  heap_order_checker heap_chk (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .cmd_i           (cmd),
    .entry_ref_i     (entry_ref),
    .entry_key_i     (entry_key),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_ref_i       (out_ref),
    .out_key_i       (out_key),
    .status_i        (status),
    .entry_count_i   (entry_count),
    .has_more_i      (has_more),
    .mismatch_o      (mismatches),
    .due_o           (due),
    .checked_o       (checked),
    .full_refusals_o (full_refusals),
    .empty_deletes_o (empty_deletes),
    .peak_fill_o     (peak_fill)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles with %0d results outstanding",
               $time, cycle_count, due);
      $display("TEST FAILED");
      $finish;
    end
  end

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_req = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 4);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);  // dense keys for ties
      1: return $urandom_range(0, 1) ? '1 : '0;
      default: return $urandom;
    endcase
  endfunction

  // valid stays up between back-to-back items; it only drops for a gap
  task automatic send_item(input logic [1:0] c, input logic [REF_BITS-1:0] r,
                           input logic [KEY_BITS-1:0] k);
    int unsigned gap;
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    cmd       <= c;
    entry_ref <= r;
    entry_key <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (c != CMD_UNUSED) sent_items++;
  endtask

  task automatic send_random(input int unsigned ins_pct, input int unsigned del_pct);
    int unsigned roll;
    logic [1:0]  c;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) c = CMD_INSERT;
    else if (roll < ins_pct + del_pct) c = CMD_DELETE;
    else if (roll < 97) c = CMD_CLEAR;
    else c = CMD_UNUSED;
    send_item(c, REF_BITS'($urandom_range(0, 65535)), pick_key());
  endtask

  initial begin
    int unsigned seg;
    int unsigned seg_len;
    int unsigned bias;
    int unsigned i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty heap, extremes, ties, unknown command, clear
    send_item(CMD_DELETE, 16'h0000, 32'h0000_0000);
    send_item(CMD_CLEAR, 16'h0000, 32'h0000_0000);
    send_item(CMD_UNUSED, '1, '1);
    send_item(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 16'h0000, 32'h0000_0000);
    send_item(CMD_INSERT, 16'hAAAA, 32'h8000_0000);
    send_item(CMD_INSERT, 16'h5555, 32'h0000_0000);
    send_item(CMD_INSERT, 16'h0001, 32'hFFFF_FFFF);
    send_item(CMD_INSERT, 16'h1234, 32'h0000_0007);
    send_item(CMD_INSERT, 16'h4321, 32'h0000_0007);
    repeat (3) send_item(CMD_DELETE, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 16'h8001, 32'h7FFF_FFFE);
    repeat (5) send_item(CMD_DELETE, 16'h0000, 32'h0000_0000);
    send_item(CMD_INSERT, 16'h00F0, 32'h0000_0005);
    send_item(CMD_INSERT, 16'h000F, 32'h0000_0003);
    send_item(CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(CMD_DELETE, 16'h0000, 32'h0000_0000);

    // mixed segments that grow, shrink or hold the heap
    seg = 0;
    while (sent_items < MIXED_ITEMS) begin
      seg_len = $urandom_range(40, 120);
      tx_idle = ($urandom_range(0, 2) != 0);
      rx_idle = ($urandom_range(0, 2) != 0);
      bias = $urandom_range(0, 2);
      if (seg == 1) squeeze_req = 1'b1;
      repeat (seg_len) begin
        case (bias)
          0: send_random(75, 20);
          1: send_random(25, 70);
          default: send_random(50, 45);
        endcase
      end
      seg++;
    end

    // fill to capacity, push against the full heap, then drain a while
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_item(CMD_CLEAR, REF_BITS'($urandom_range(0, 65535)), $urandom);
    for (i = 0; i < CAPACITY; i++) begin
      send_item(CMD_INSERT, REF_BITS'($urandom_range(0, 65535)), pick_key());
    end
    repeat (3) send_item(CMD_INSERT, REF_BITS'($urandom_range(0, 65535)), pick_key());
    repeat (50) send_item(CMD_DELETE, REF_BITS'($urandom_range(0, 65535)), $urandom);
    repeat (40) send_random(50, 45);
    send_item(CMD_CLEAR, REF_BITS'($urandom_range(0, 65535)), $urandom);

    // closing stretch at full rate on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (CLOSING_ITEMS) send_random(50, 45);
    in_valid <= 1'b0;

    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due != 0) $display("%0t: %0d results never arrived", $time, due);

    $display("covered %0d commands and %0d checked results, peak fill %0d of %0d",
             sent_items, checked, peak_fill, CAPACITY);
    $display("refused inserts on a full heap: %0d, deletes on an empty heap: %0d, mismatches: %0d",
             full_refusals, empty_deletes, mismatches);
    if (mismatches == 0 && due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bmh_pkg.sv
rtl/bmh_ram.sv
rtl/bmh_ctrl.sv
rtl/bmh_out_reg.sv
rtl/binary_min_heap_priority_queue.sv
rtl/bmh_checker.sv
tb/heap_order_checker.sv
tb/tb_binary_min_heap_priority_queue.sv
